// ----- src/dar_pkg.sv -----
// ---------------------------------------------------------------------------
// dar_pkg: shared types and range table for the output autoranger
// Holds the payload structs, register indexes and the constant table of the
// twelve converter output ranges with its lookup helpers.
// ---------------------------------------------------------------------------
package dar_pkg;

   // fixed-point and field widths
   localparam int VOLT_FRACTION_BITS = 16;
   localparam int DWELL_COUNTER_BITS = 16;
   localparam int VOLT_W             = 24;
   localparam int RANGE_W            = 4;
   localparam int RANGE_COUNT        = 12;
   localparam int FRAC_W             = 16;
   localparam int DWELL_W            = 16;
   localparam int CSR_INDEX_W        = 4;
   localparam int CSR_DATA_W         = 16;
   localparam int TABLE_W            = 7;
   // scaled bounds: table value times 2^VOLT_FRACTION_BITS, plus sign headroom
   localparam int BOUND_W            = TABLE_W + VOLT_FRACTION_BITS + 1;
   localparam int VOLT_EXT_W         = (BOUND_W > VOLT_W) ? BOUND_W : VOLT_W;
   // table value times margin fraction
   localparam int PROD_W             = TABLE_W + FRAC_W + 1;
   // margin compare: volts * 2^16 against product * 2^VOLT_FRACTION_BITS
   localparam int MARGIN_A_W         = VOLT_W + FRAC_W;
   localparam int MARGIN_B_W         = PROD_W + VOLT_FRACTION_BITS;
   localparam int MARGIN_CMP_W       = ((MARGIN_A_W > MARGIN_B_W) ? MARGIN_A_W : MARGIN_B_W) + 1;
   localparam int DWELL_CMP_W        =
      (DWELL_COUNTER_BITS > DWELL_W) ? DWELL_COUNTER_BITS : DWELL_W;

   localparam logic [RANGE_W-1:0] LAST_RANGE = RANGE_W'(RANGE_COUNT - 1);

   // register indexes on the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_RANGE      = 4'd0,
      CSR_CEILING_RANGE   = 4'd1,
      CSR_MARGIN_FRACTION = 4'd2,
      CSR_DWELL_SAMPLES   = 4'd3
   } csr_index_type;

   typedef logic [RANGE_W-1:0] range_idx_type;

   typedef struct packed {
      logic signed [VOLT_W-1:0] volts;
      range_idx_type            current_range;
   } req_data_type;

   typedef struct packed {
      logic          switch_now;
      range_idx_type target_range;
   } rsp_data_type;

   typedef struct packed {
      range_idx_type       base_range;
      range_idx_type       ceiling_range;
      logic [FRAC_W-1:0]   margin_fraction;
      logic [DWELL_W-1:0]  dwell_samples;
   } csr_regs_type;

   // lower bound of each range in whole volts
   function automatic logic signed [TABLE_W-1:0] range_lo(input range_idx_type r);
      logic signed [TABLE_W-1:0] lo;
      case (r)
         4'd4:    lo = -7'sd5;
         4'd5:    lo = -7'sd10;
         4'd6:    lo = -7'sd20;
         4'd10:   lo = -7'sd6;
         4'd11:   lo = -7'sd12;
         default: lo = 7'sd0;
      endcase
      return lo;
   endfunction

   // upper bound of each range in whole volts
   function automatic logic signed [TABLE_W-1:0] range_hi(input range_idx_type r);
      logic signed [TABLE_W-1:0] hi;
      case (r)
         4'd0, 4'd4:  hi = 7'sd5;
         4'd1, 4'd5:  hi = 7'sd10;
         4'd2, 4'd6:  hi = 7'sd20;
         4'd3:        hi = 7'sd40;
         4'd7, 4'd10: hi = 7'sd6;
         4'd8, 4'd11: hi = 7'sd12;
         4'd9:        hi = 7'sd24;
         default:     hi = 7'sd12;
      endcase
      return hi;
   endfunction

   // width of a range in whole volts
   function automatic logic [TABLE_W-1:0] range_span(input range_idx_type r);
      return TABLE_W'(range_hi(r) - range_lo(r));
   endfunction

   // ranges ordered by span, ties kept in table order
   function automatic range_idx_type pick_order(input range_idx_type k);
      range_idx_type r;
      case (k)
         4'd0:    r = 4'd0;
         4'd1:    r = 4'd7;
         4'd2:    r = 4'd1;
         4'd3:    r = 4'd4;
         4'd4:    r = 4'd8;
         4'd5:    r = 4'd10;
         4'd6:    r = 4'd2;
         4'd7:    r = 4'd5;
         4'd8:    r = 4'd9;
         4'd9:    r = 4'd11;
         4'd10:   r = 4'd3;
         4'd11:   r = 4'd6;
         default: r = LAST_RANGE;
      endcase
      return r;
   endfunction

   // unused codes above the table map to the last range
   function automatic range_idx_type clamp_index(input range_idx_type r);
      return (r > LAST_RANGE) ? LAST_RANGE : r;
   endfunction

   function automatic logic encloses(input range_idx_type outer, input range_idx_type inner);
      return (range_lo(outer) <= range_lo(inner)) && (range_hi(outer) >= range_hi(inner));
   endfunction

   // whole volts to volt fixed point
   function automatic logic signed [BOUND_W-1:0] scaled(input logic signed [TABLE_W-1:0] whole);
      logic signed [BOUND_W-1:0] ext;
      ext = {{(BOUND_W-TABLE_W){whole[TABLE_W-1]}}, whole};
      return ext <<< VOLT_FRACTION_BITS;
   endfunction

endpackage

// ----- src/dar_decide.sv -----
// ---------------------------------------------------------------------------
// dar_decide: range pick and switch decision for one sample
// Searches the range table for the narrowest allowed range that holds the
// voltage, then decides between an immediate switch, a dwell-qualified
// narrowing switch, or no switch, and gives the next dwell count.
// ---------------------------------------------------------------------------
module dar_decide
   import dar_pkg::*;
(
   input  req_data_type                   item,
   input  csr_regs_type                   regs,
   input  logic [DWELL_COUNTER_BITS-1:0]  dwell_count,
   output rsp_data_type                   result,
   output logic [DWELL_COUNTER_BITS-1:0]  dwell_next
);

   range_idx_type                   cur;
   range_idx_type                   base;
   range_idx_type                   ceil_r;
   range_idx_type                   want;
   logic signed [VOLT_EXT_W-1:0]    v_ext;
   logic [RANGE_COUNT-1:0]          holds_vec;
   logic [RANGE_COUNT-1:0]          cand;
   logic                            cur_hold;
   logic signed [FRAC_W:0]          frac_s;
   logic signed [PROD_W-1:0]        lo_prod;
   logic signed [PROD_W-1:0]        hi_prod;
   logic signed [MARGIN_CMP_W-1:0]  v_cmp;
   logic signed [MARGIN_CMP_W-1:0]  lo_cmp;
   logic signed [MARGIN_CMP_W-1:0]  hi_cmp;
   logic                            margin_ok;
   logic                            wider_or_same;
   logic [DWELL_COUNTER_BITS-1:0]   dwell_inc;
   logic                            dwell_reached;

   assign cur    = clamp_index(item.current_range);
   assign base   = clamp_index(regs.base_range);
   assign ceil_r = clamp_index(regs.ceiling_range);
   assign v_ext  = {{(VOLT_EXT_W-VOLT_W){item.volts[VOLT_W-1]}}, item.volts};

   // per-range bound test and allowed mask
   always_comb begin
      for (int r = 0; r < RANGE_COUNT; r++) begin
         holds_vec[r] = (v_ext >= VOLT_EXT_W'(scaled(range_lo(RANGE_W'(r))))) &&
                        (v_ext <= VOLT_EXT_W'(scaled(range_hi(RANGE_W'(r)))));
         cand[r]      = holds_vec[r] && encloses(RANGE_W'(r), base) &&
                        encloses(ceil_r, RANGE_W'(r));
      end
   end

   // narrowest candidate wins, ceiling when none fits
   always_comb begin
      want = ceil_r;
      for (int k = RANGE_COUNT - 1; k >= 0; k--) begin
         if (cand[pick_order(RANGE_W'(k))]) begin
            want = pick_order(RANGE_W'(k));
         end
      end
   end

   assign cur_hold      = holds_vec[cur];
   assign wider_or_same = (want == cur) || (range_span(want) >= range_span(cur));

   // margin bounds of the pick: volts*2^16 against bound*frac*2^fraction_bits
   assign frac_s  = {1'b0, regs.margin_fraction};
   assign lo_prod = PROD_W'(range_lo(want)) * PROD_W'(frac_s);
   assign hi_prod = PROD_W'(range_hi(want)) * PROD_W'(frac_s);
   assign v_cmp   = MARGIN_CMP_W'(item.volts) <<< FRAC_W;
   assign lo_cmp  = MARGIN_CMP_W'(lo_prod) <<< VOLT_FRACTION_BITS;
   assign hi_cmp  = MARGIN_CMP_W'(hi_prod) <<< VOLT_FRACTION_BITS;
   assign margin_ok = (v_cmp >= lo_cmp) && (v_cmp <= hi_cmp);

   // saturating dwell count
   assign dwell_inc     = (dwell_count == '1) ? dwell_count
                                              : DWELL_COUNTER_BITS'(dwell_count + 1'b1);
   assign dwell_reached = DWELL_CMP_W'(dwell_inc) >= DWELL_CMP_W'(regs.dwell_samples);

   // switch decision
   always_comb begin
      result.switch_now   = 1'b0;
      result.target_range = item.current_range;
      dwell_next          = '0;
      if (!cur_hold) begin
         if (want != cur) begin
            result.switch_now   = 1'b1;
            result.target_range = want;
         end
      end else if (!wider_or_same && margin_ok) begin
         dwell_next = dwell_inc;
         if (dwell_reached) begin
            result.switch_now   = 1'b1;
            result.target_range = want;
         end
      end
   end

endmodule

// ----- src/dac_output_autorange.sv -----
// ---------------------------------------------------------------------------
// dac_output_autorange: output range selection for a multi-range converter
// Takes one requested voltage per beat and tells whether the converter
// should change range, with hysteresis and a dwell before narrowing.
// ---------------------------------------------------------------------------
// Usage
//   req channel: one beat per output sample, volts (signed, 16 fraction
//   bits) and the range index now applied.
//   rsp channel: one beat per request, in order: switch_now and the range
//   to use; target_range echoes current_range when no switch is asked.
//   csr channel: write-only, index 0..3 selects base_range, ceiling_range,
//   margin_fraction, dwell_samples; other indexes are ignored. Always ready.
//   Write it only with no request in flight.
// Timing
//   rsp valid follows the req beat: the beat lands in an input register,
//   then the range pick and decision run in one pass into the result
//   register, which drives the rsp channel.
//   Throughput is one beat per cycle while rsp_ready stays high; the dwell
//   count is updated as each sample moves into the result register.
// Reset and stall
//   Reset restores the register defaults and clears the dwell count.
//   When rsp_ready is low the result holds and an empty input register
//   still takes one more beat before req_ready drops.
// ---------------------------------------------------------------------------
module dac_output_autorange
   import dar_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_data_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_data_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   csr_regs_type                  csr_regs_ff;
   csr_regs_type                  csr_regs_in;
   logic                          in_valid_ff;
   req_data_type                  in_data_ff;
   logic                          out_valid_ff;
   rsp_data_type                  out_data_ff;
   logic [DWELL_COUNTER_BITS-1:0] dwell_count_ff;
   logic [DWELL_COUNTER_BITS-1:0] dwell_count_in;
   rsp_data_type                  decide_result;
   logic                          advance;

   // register writes
   assign csr_ready = 1'b1;

   always_comb begin
      csr_regs_in = csr_regs_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BASE_RANGE:      csr_regs_in.base_range      = csr_wdata[RANGE_W-1:0];
            CSR_CEILING_RANGE:   csr_regs_in.ceiling_range   = csr_wdata[RANGE_W-1:0];
            CSR_MARGIN_FRACTION: csr_regs_in.margin_fraction = csr_wdata[FRAC_W-1:0];
            CSR_DWELL_SAMPLES:   csr_regs_in.dwell_samples   = csr_wdata[DWELL_W-1:0];
            default:             csr_regs_in = csr_regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_regs_ff.base_range      <= RANGE_W'(0);
         csr_regs_ff.ceiling_range   <= LAST_RANGE;
         csr_regs_ff.margin_fraction <= FRAC_W'(58982);
         csr_regs_ff.dwell_samples   <= DWELL_W'(16);
      end else begin
         csr_regs_ff <= csr_regs_in;
      end
   end

   // pipeline flow
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   dar_decide u_decide (
      .item        (in_data_ff),
      .regs        (csr_regs_ff),
      .dwell_count (dwell_count_ff),
      .result      (decide_result),
      .dwell_next  (dwell_count_in)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // result register and dwell state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         dwell_count_ff <= '0;
      end else begin
         if (advance) begin
            out_valid_ff   <= 1'b1;
            dwell_count_ff <= dwell_count_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= decide_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ----- src/dar_checker.sv -----
// ---------------------------------------------------------------------------
// dar_checker: port-level checks for the output autoranger
// Watches the ports for result hold under stall, sane switch targets, a quiet
// result channel after reset and a free input side with an empty result register.
// ---------------------------------------------------------------------------
module dar_checker
   import dar_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_data_type rsp_data
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   // a requested switch always names a table entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.switch_now |-> rsp_data.target_range <= LAST_RANGE)
      else $error("switch target outside range table");

   // no result beat right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // input side always free while the result register is empty
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty result register");

endmodule

bind dac_output_autorange dar_checker u_dar_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
